// ===== rtl/tpms_pkg.sv =====
// Shared constants and types for the tracked pointer table.
`default_nettype none
package tpms_pkg;
  localparam int TableDepthDefault = 64;
  localparam int CountWidthDefault = 16;

  localparam logic [2:0] KIND_ALLOC   = 3'd0;
  localparam logic [2:0] KIND_TRACK   = 3'd1;
  localparam logic [2:0] KIND_UNTRACK = 3'd2;
  localparam logic [2:0] KIND_RENAME  = 3'd3;
  localparam logic [2:0] KIND_STACK   = 3'd4;
  localparam logic [2:0] KIND_HEAP    = 3'd5;
  localparam logic [2:0] KIND_SWEEP   = 3'd6;
  localparam logic [2:0] KIND_FLUSH   = 3'd7;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NOMATCH  = 3'd4;
  localparam logic [2:0] ST_FREED    = 3'd5;

  // Command broadcast from the controller to every cell
  typedef struct packed {
    logic        do_append;
    logic        do_remove;
    logic        do_rename;
    logic        do_mark;
    logic        do_sweep;
    logic        do_flush;
    logic [63:0] ptr;
    logic [63:0] new_ptr;
  } tpms_cmd_t;
endpackage
`default_nettype wire

// ===== rtl/tpms_cell.sv =====
// One table entry: holds pointer and counts, shifts toward the front on removal.
`default_nettype none
module tpms_cell import tpms_pkg::*; #(
  parameter int CountWidth = CountWidthDefault
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire tpms_cmd_t             cmd,
  // entry behind this one
  input  wire logic                  nb_valid,
  input  wire logic [63:0]           nb_ptr,
  input  wire logic [CountWidth-1:0] nb_refs,
  input  wire logic [CountWidth-1:0] nb_found,
  // first match lies before this cell
  input  wire logic                  hit_before,
  // this cell is the first empty slot
  input  wire logic                  append_here,
  // the front cell of the sweep/flush shift, removal at or before here
  input  wire logic                  shift_here,
  output logic                       valid,
  output logic [63:0]                ptr,
  output logic [CountWidth-1:0]      refs,
  output logic [CountWidth-1:0]      found,
  output logic                       hit
);
  localparam logic [CountWidth-1:0] CountMax = '1;

  logic first_hit;

  assign hit       = valid && (ptr == cmd.ptr);
  assign first_hit = hit && !hit_before;

  // Update control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (append_here) begin
      valid <= 1'b1;
    end else if (shift_here) begin
      valid <= nb_valid;
    end
  end

  // Update payload
  always_ff @(posedge clk) begin
    if (append_here) begin
      ptr   <= cmd.ptr;
      refs  <= CountWidth'(1);
      found <= '0;
    end else if (shift_here) begin
      ptr   <= nb_ptr;
      refs  <= nb_refs;
      found <= nb_found;
    end else if (cmd.do_rename && first_hit) begin
      ptr <= cmd.new_ptr;
    end else if (cmd.do_mark && first_hit && found != CountMax) begin
      found <= found + CountWidth'(1);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/tracked_pointer_mark_sweep_table_core.sv =====
// Top level: controller and chain of table cells.
// The result is loaded into the output register at the accepting edge.
// Single-result kinds are accepted back to back while the output is not stalled;
// sweep and flush hold the input stalled while the walk scans each live entry at the
// table head, and the walk pauses once more when the last entry is freed after an earlier one.
// Sweep walks the chain head: each step the front cell is freed or rotated; the
// walk pauses while the output is stalled.
// Reset (rst, synchronous) empties the table, clears heap_end and heap_start.
`default_nettype none
module tracked_pointer_mark_sweep_table_core import tpms_pkg::*; #(
  parameter int TableDepth = TableDepthDefault,
  parameter int CountWidth = CountWidthDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  kind,
  input  wire logic [63:0] pointer,
  input  wire logic [63:0] new_pointer,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic [63:0]      freed_pointer,
  output logic             last
);
  localparam int CntW = $clog2(TableDepth + 1);

  logic [63:0] heap_start, heap_end;
  logic [CntW-1:0] fill, remain;
  logic busy;        // sweep/flush walk in progress
  logic is_flush;
  logic any_freed;
  logic step;        // walk advances this cycle
  logic pend_valid;
  logic [63:0] pend_ptr;

  tpms_cmd_t cmd;
  logic [TableDepth-1:0] v, hit, hit_before, app, shf;
  logic [63:0]           p [TableDepth];
  logic [CountWidth-1:0] rf [TableDepth];
  logic [CountWidth-1:0] fd [TableDepth];

  logic accept, out_free, any_hit, full, in_bounds;
  logic emit;
  logic [2:0] emit_st;
  logic [63:0] emit_fp;
  logic emit_last;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) heap_start <= '0;
    else if (cfg_valid) heap_start <= cfg_data;
  end

  assign out_free = !out_valid || !out_stall;
  assign in_stall = busy || !out_free;
  assign accept   = in_valid && !in_stall;

  // Match chain: first hit detection
  always_comb begin
    hit_before[0] = 1'b0;
    for (int i = 1; i < TableDepth; i++) hit_before[i] = hit_before[i-1] | hit[i-1];
  end
  assign any_hit = hit_before[TableDepth-1] | hit[TableDepth-1];
  assign full    = fill == CntW'(TableDepth);

  always_comb begin
    in_bounds = 1'b0;
    if (kind == KIND_STACK)
      in_bounds = pointer != '0 && pointer >= heap_start && pointer <= heap_end;
    else if (kind == KIND_HEAP)
      in_bounds = pointer > heap_start && pointer < heap_end;
  end

  // Walk head: front cell decides free or keep during sweep/flush
  logic head_free;
  assign head_free = busy && (is_flush || fd[0] == '0);

  // Advance the walk only when the output can take data; when the last entry is
  // freed behind a held one, send the held one first and step once it has been sent
  assign step = busy && out_free && !(remain == CntW'(1) && head_free && pend_valid);

  always_comb begin
    cmd = '0;
    cmd.ptr     = pointer;
    cmd.new_ptr = new_pointer;
    if (accept) begin
      unique case (kind)
        KIND_ALLOC, KIND_TRACK: cmd.do_append = !any_hit && !full;
        KIND_UNTRACK:           cmd.do_remove = any_hit;
        KIND_RENAME:            cmd.do_rename = 1'b1;
        KIND_STACK, KIND_HEAP:  cmd.do_mark   = in_bounds;
        default: ;
      endcase
    end
  end

  // Per-cell append and shift enables
  always_comb begin
    for (int i = 0; i < TableDepth; i++) begin
      app[i] = cmd.do_append && (fill == CntW'(i));
      // Untrack shifts at and after the first hit; the walk rotates the
      // whole live prefix, dropping or keeping the head.
      shf[i] = (cmd.do_remove && (hit[i] || hit_before[i])) || step;
    end
  end

  // Rotation: kept head re-enters behind the remaining unwalked entries
  logic [CntW-1:0] tail_pos;
  assign tail_pos = fill - CntW'(1);

  genvar g;
  generate
    for (g = 0; g < TableDepth; g++) begin : g_cell
      logic nv;
      logic [63:0] np;
      logic [CountWidth-1:0] nr, nf;
      logic rot;
      assign rot = busy && !head_free && (tail_pos == CntW'(g));
      if (g == TableDepth - 1) begin : g_end
        assign nv = rot;
        assign np = p[0];
        assign nr = fd[0];
        assign nf = '0;
      end else begin : g_mid
        assign nv = rot ? 1'b1 : (busy && head_free && tail_pos == CntW'(g)) ? 1'b0
                        : v[g+1];
        assign np = rot ? p[0] : p[g+1];
        assign nr = rot ? fd[0] : rf[g+1];
        assign nf = rot ? '0 : fd[g+1];
      end
      tpms_cell #(.CountWidth(CountWidth)) u_cell (
        .clk(clk), .rst(rst), .cmd(cmd),
        .nb_valid(nv), .nb_ptr(np), .nb_refs(nr), .nb_found(nf),
        .hit_before(hit_before[g]), .append_here(app[g]),
        .shift_here(shf[g] && !(busy && CntW'(g) >= fill)),
        .valid(v[g]), .ptr(p[g]), .refs(rf[g]), .found(fd[g]), .hit(hit[g])
      );
    end
  endgenerate

  // Controller
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0; heap_end <= '0; busy <= 1'b0; is_flush <= 1'b0;
      remain <= '0; any_freed <= 1'b0;
    end else if (busy) begin
      if (step) begin
        if (head_free) fill <= fill - CntW'(1);
        if (head_free) any_freed <= 1'b1;
        remain <= remain - CntW'(1);
        if (remain == CntW'(1)) busy <= 1'b0;
      end
    end else if (accept) begin
      if (cmd.do_append) fill <= fill + CntW'(1);
      if (cmd.do_remove) fill <= fill - CntW'(1);
      if (kind == KIND_ALLOC && pointer > heap_end) heap_end <= pointer;
      if (kind == KIND_RENAME && new_pointer > heap_end) heap_end <= new_pointer;
      if ((kind == KIND_SWEEP || kind == KIND_FLUSH) && fill != '0) begin
        busy <= 1'b1; remain <= fill; any_freed <= 1'b0;
        is_flush <= kind == KIND_FLUSH;
      end
    end
  end

  // Result selection; during the walk a freed result carries last only if no
  // later entry will be freed, so hold each freed result until the next.
  always_comb begin
    emit = 1'b0; emit_st = ST_OK; emit_fp = '0; emit_last = 1'b1;
    if (busy) begin
      if (head_free && pend_valid) begin
        emit = 1'b1; emit_st = ST_FREED; emit_fp = pend_ptr; emit_last = 1'b0;
      end else if (remain == CntW'(1)) begin
        if (pend_valid && !head_free) begin
          emit = 1'b1; emit_st = ST_FREED; emit_fp = pend_ptr;
        end else if (head_free) begin
          emit = 1'b1; emit_st = ST_FREED; emit_fp = p[0];
        end else if (!any_freed) begin
          emit = 1'b1;
        end
      end
    end else if (accept) begin
      emit = !((kind == KIND_SWEEP || kind == KIND_FLUSH) && fill != '0);
      priority case (1'b1)
        (kind == KIND_ALLOC || kind == KIND_TRACK):
          emit_st = any_hit ? ST_DUP : (full ? ST_FULL : ST_OK);
        (kind == KIND_UNTRACK || kind == KIND_RENAME):
          emit_st = any_hit ? ST_OK : ST_NOTFOUND;
        (kind == KIND_STACK || kind == KIND_HEAP):
          emit_st = (in_bounds && any_hit) ? ST_OK : ST_NOMATCH;
        default: emit_st = ST_OK;
      endcase
    end
  end

  // Hold the most recent freed pointer until its successor is known
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (busy && out_free) begin
      if (remain == CntW'(1)) pend_valid <= 1'b0;
      else if (head_free) pend_valid <= 1'b1;
    end
    if (step && head_free) pend_ptr <= p[0];
  end

  // Output register; walk only advances while the register can take data
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_free) out_valid <= emit;
  end
  always_ff @(posedge clk) begin
    if (out_free && emit) begin
      status <= emit_st; freed_pointer <= emit_fp; last <= emit_last;
    end
  end
endmodule
`default_nettype wire

// ===== dv/tb_tracked_pointer_mark_sweep_table_core.sv =====
// Testbench for the tracked pointer mark-and-sweep table core.
`default_nettype none
module tb_tracked_pointer_mark_sweep_table_core;
  import tpms_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = 64;
  localparam logic [15:0] CountMax = 16'hFFFF;
  localparam logic [63:0] PoolBase = 64'h0000_1000_0000_0000;
  localparam logic [63:0] AllOnes = '1;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [2:0]  kind = KIND_SWEEP;
  logic [63:0] pointer = '0;
  logic [63:0] new_pointer = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [2:0]  status;
  logic [63:0] freed_pointer;
  logic        last;

  // Pinned status travels with the payload for directed rows
  logic        pin_en = 0;
  logic [2:0]  pin_status = ST_OK;

  typedef struct {
    logic [2:0]  st;
    logic [63:0] fp;
    logic        lst;
  } release_t;

  typedef struct {
    logic [2:0]  k;
    logic [63:0] p;
    logic [63:0] np;
    logic        pin;
    logic [2:0]  st;
  } dir_row_t;

  release_t    pending_q[$];
  int          errors = 0;
  bit          idle_on = 1;
  bit          hold_req = 0;
  bit          hold_seen = 0;
  int          hold_cnt = 0;
  int          stall_cnt = 0;

  // Shadow table state
  logic [63:0] sh_ptr[Depth];
  logic [15:0] sh_refs[Depth];
  logic [15:0] sh_found[Depth];
  int          sh_fill = 0;
  logic [63:0] sh_heap_end = '0;
  logic [63:0] sh_heap_start = '0;

  tracked_pointer_mark_sweep_table_core dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .pointer(pointer), .new_pointer(new_pointer),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .freed_pointer(freed_pointer), .last(last)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  function automatic int lookup(logic [63:0] p);
    for (int i = 0; i < sh_fill; i++)
      if (sh_ptr[i] == p) return i;
    return -1;
  endfunction

  function automatic logic [2:0] add_entry(logic [63:0] p);
    if (lookup(p) >= 0) return ST_DUP;
    if (sh_fill >= Depth) return ST_FULL;
    sh_ptr[sh_fill] = p;
    sh_refs[sh_fill] = 16'd1;
    sh_found[sh_fill] = '0;
    sh_fill++;
    return ST_OK;
  endfunction

  function automatic logic [2:0] mark_word(logic [63:0] w);
    int i;
    i = lookup(w);
    if (i < 0) return ST_NOMATCH;
    if (sh_found[i] < CountMax) sh_found[i]++;
    return ST_OK;
  endfunction

  function automatic void push_release(logic [2:0] st, logic [63:0] fp, logic lst);
    release_t r;
    r.st = st;
    r.fp = fp;
    r.lst = lst;
    pending_q.push_back(r);
  endfunction

  // Update the shadow table for one transaction; return the first status
  function automatic logic [2:0] predict_table(logic [2:0] k, logic [63:0] p,
                                               logic [63:0] np);
    logic [2:0] st;
    int i;
    int w;
    int n;
    st = ST_OK;
    n = 0;
    case (k)
      KIND_ALLOC: begin
        st = add_entry(p);
        if (p > sh_heap_end) sh_heap_end = p;
      end
      KIND_TRACK: st = add_entry(p);
      KIND_UNTRACK: begin
        i = lookup(p);
        if (i < 0) st = ST_NOTFOUND;
        else begin
          for (int j = i; j + 1 < sh_fill; j++) begin
            sh_ptr[j] = sh_ptr[j+1];
            sh_refs[j] = sh_refs[j+1];
            sh_found[j] = sh_found[j+1];
          end
          sh_fill--;
        end
      end
      KIND_RENAME: begin
        i = lookup(p);
        if (i < 0) st = ST_NOTFOUND;
        else sh_ptr[i] = np;
        if (np > sh_heap_end) sh_heap_end = np;
      end
      KIND_STACK:
        st = (p != 0 && p >= sh_heap_start && p <= sh_heap_end) ? mark_word(p) : ST_NOMATCH;
      KIND_HEAP:
        st = (p > sh_heap_start && p < sh_heap_end) ? mark_word(p) : ST_NOMATCH;
      KIND_SWEEP: begin
        w = 0;
        for (int r = 0; r < sh_fill; r++) begin
          if (sh_found[r] == 0) begin
            push_release(ST_FREED, sh_ptr[r], 1'b0);
            n++;
          end else begin
            sh_ptr[w] = sh_ptr[r];
            sh_refs[w] = sh_found[r];
            sh_found[w] = '0;
            w++;
          end
        end
        sh_fill = w;
      end
      default: begin
        for (int r = 0; r < sh_fill; r++) begin
          push_release(ST_FREED, sh_ptr[r], 1'b0);
          n++;
        end
        sh_fill = 0;
      end
    endcase
    if (n > 0) begin
      pending_q[pending_q.size()-1].lst = 1'b1;
      return ST_FREED;
    end
    push_release(st, '0, 1'b1);
    return st;
  endfunction

  // Observe accepted transactions on all three channels
  always @(posedge clk) begin
    logic [2:0] first_st;
    release_t e;
    if (!rst) begin
      if (cfg_valid && cfg_ready) sh_heap_start = cfg_data;
      if (in_valid && !in_stall) begin
        first_st = predict_table(kind, pointer, new_pointer);
        if (pin_en && first_st != pin_status) begin
          $display("%0t: pinned status mismatch: expected %0d actual %0d",
                   $time, pin_status, first_st);
          errors++;
        end
      end
      if (out_valid && !out_stall) begin
        if (pending_q.size() == 0) begin
          $display("%0t: unexpected result: expected none actual %0d/%h/%0d",
                   $time, status, freed_pointer, last);
          errors++;
        end else begin
          e = pending_q.pop_front();
          if (status !== e.st) begin
            $display("%0t: status mismatch: expected %0d actual %0d", $time, e.st, status);
            errors++;
          end
          if (freed_pointer !== e.fp) begin
            $display("%0t: freed_pointer mismatch: expected %h actual %h",
                     $time, e.fp, freed_pointer);
            errors++;
          end
          if (last !== e.lst) begin
            $display("%0t: last mismatch: expected %0d actual %0d", $time, e.lst, last);
            errors++;
          end
        end
      end
    end
  end

  // Result side stall: random per transaction, plus one long hold-off
  always @(posedge clk) begin
    int n;
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_req && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_cnt <= 300;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      out_stall <= 1'b1;
    end else if (out_valid && !out_stall) begin
      n = idle_on ? $urandom_range(0, 18) : 0;
      out_stall <= (n > 0);
      stall_cnt <= (n > 0) ? n - 1 : 0;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_item(logic [2:0] k, logic [63:0] p, logic [63:0] np,
                           logic pin = 1'b0, logic [2:0] pst = ST_OK);
    int gap;
    gap = idle_on ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    pointer <= p;
    new_pointer <= np;
    pin_en <= pin;
    pin_status <= pst;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  // Stop offering, then wait for every expected result plus settle time
  task automatic drain();
    in_valid <= 1'b0;
    pin_en <= 1'b0;
    do @(posedge clk); while (pending_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_heap_start(logic [63:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] pick_pointer();
    case ($urandom_range(0, 9))
      0: return {$urandom, $urandom};
      1: return AllOnes;
      2: return '0;
      default: return PoolBase + 64'(8 * $urandom_range(0, 15));
    endcase
  endfunction

  task automatic random_item();
    int r;
    logic [2:0] k;
    r = $urandom_range(0, 99);
    if (r < 25) k = KIND_ALLOC;
    else if (r < 33) k = KIND_TRACK;
    else if (r < 41) k = KIND_UNTRACK;
    else if (r < 49) k = KIND_RENAME;
    else if (r < 71) k = KIND_STACK;
    else if (r < 89) k = KIND_HEAP;
    else if (r < 97) k = KIND_SWEEP;
    else k = KIND_FLUSH;
    send_item(k, pick_pointer(), pick_pointer());
  endtask

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    dir_row_t dir_tab[21];
    logic [63:0] p0;
    logic [63:0] p1;
    logic [63:0] p2;
    p0 = PoolBase;
    p1 = PoolBase + 64'd8;
    p2 = PoolBase + 64'd16;
    dir_tab = '{
      '{KIND_UNTRACK, p0, '0, 1'b1, ST_NOTFOUND},
      '{KIND_RENAME,  p0, p1, 1'b1, ST_NOTFOUND},
      '{KIND_SWEEP,   '0, '0, 1'b1, ST_OK},
      '{KIND_FLUSH,   '0, '0, 1'b1, ST_OK},
      '{KIND_STACK,   '0, '0, 1'b1, ST_NOMATCH},
      '{KIND_HEAP,    AllOnes, '0, 1'b1, ST_NOMATCH},
      '{KIND_ALLOC,   p0, '0, 1'b1, ST_OK},
      '{KIND_ALLOC,   p0, '0, 1'b1, ST_DUP},
      '{KIND_TRACK,   p1, '0, 1'b1, ST_OK},
      '{KIND_TRACK,   p1, '0, 1'b1, ST_DUP},
      '{KIND_ALLOC,   AllOnes, AllOnes, 1'b1, ST_OK},
      '{KIND_STACK,   AllOnes, '0, 1'b0, ST_OK},
      '{KIND_HEAP,    p1, '0, 1'b0, ST_OK},
      '{KIND_STACK,   '0, AllOnes, 1'b1, ST_NOMATCH},
      '{KIND_RENAME,  p0, p2, 1'b0, ST_OK},
      '{KIND_HEAP,    p2, '0, 1'b0, ST_OK},
      '{KIND_SWEEP,   '0, '0, 1'b0, ST_OK},
      '{KIND_UNTRACK, p1, '0, 1'b0, ST_OK},
      '{KIND_ALLOC,   '0, '0, 1'b0, ST_OK},
      '{KIND_STACK,   p2, '0, 1'b0, ST_OK},
      '{KIND_FLUSH,   '0, '0, 1'b0, ST_OK}
    };

    // Hold reset, then start from a known heap base
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_heap_start('0);

    // Walk the directed table
    foreach (dir_tab[i])
      send_item(dir_tab[i].k, dir_tab[i].p, dir_tab[i].np, dir_tab[i].pin, dir_tab[i].st);
    drain();

    // Random phases across heap base settings; one phase with a long hold-off
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_heap_start(PoolBase - 64'd8);
        1: write_heap_start(AllOnes);
        2: write_heap_start({$urandom, $urandom});
        3: write_heap_start(PoolBase + 64'd40);
        default: write_heap_start('0);
      endcase
      if (ph == 4) begin
        idle_on = 0;
        hold_req <= 1'b1;
      end
      repeat (57) random_item();
      drain();
      idle_on = 1;
    end

    // Fill the table past its depth, then release everything
    send_item(KIND_FLUSH, '0, '0);
    for (int i = 0; i < 70; i++)
      send_item(i % 2 ? KIND_TRACK : KIND_ALLOC, PoolBase + 64'(8 * i), '0);
    send_item(KIND_SWEEP, '0, '0);
    drain();

    write_heap_start(AllOnes);
    send_item(KIND_FLUSH, '0, '0);
    drain();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire
